FILE: src/hkrd_pkg.sv
package hkrd_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int IDX_W     = 3;

    localparam logic [7:0] MIN_KEY   = 8'h04;
    localparam logic [7:0] MAX_USAGE = 8'h75;
    localparam logic [4:0] MOD_BASE  = 5'b11100;
    localparam logic [7:0] NO_CODE   = 8'hFF;
    localparam logic [7:0] ROLLOVER  = 8'h01;

    // Candidate groups, walked in this order for every report.
    localparam logic [2:0] PH_GMOD = 3'd0;
    localparam logic [2:0] PH_GKEY = 3'd1;
    localparam logic [2:0] PH_MOD  = 3'd2;
    localparam logic [2:0] PH_REL  = 3'd3;
    localparam logic [2:0] PH_PRS  = 3'd4;

    localparam logic [IDX_W-1:0] MOD_LAST = 3'd7;
    localparam logic [IDX_W-1:0] KEY_LAST = 3'(KEY_SLOTS - 1);

    localparam logic [6:0] MOD_ROM [0:7] = '{
        7'h3b, 7'h38, 7'h3a, 7'h37, 7'h3e, 7'h3c, 7'h3d, 7'h36
    };

    // Usage to legacy key code; entries above the last usage read as no code.
    localparam logic [7:0] LEGACY_ROM [0:127] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h0b, 8'h08, 8'h02, 8'h0e, 8'h03, 8'h05, 8'h04, 8'h22, 8'h26, 8'h28, 8'h25,
        8'h2e, 8'h2d, 8'h1f, 8'h23, 8'h0c, 8'h0f, 8'h01, 8'h11, 8'h20, 8'h09, 8'h0d, 8'h07,
        8'h10, 8'h06, 8'h12, 8'h13, 8'h14, 8'h15, 8'h17, 8'h16, 8'h1a, 8'h1c, 8'h19, 8'h1d,
        8'h24, 8'h35, 8'h33, 8'h30, 8'h31, 8'h1b, 8'h18, 8'h21, 8'h1e, 8'h2a, 8'h2a, 8'h29,
        8'h27, 8'h32, 8'h2b, 8'h2f, 8'h2c, 8'h39, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h60, 8'h61,
        8'h62, 8'h64, 8'h65, 8'h6d, 8'h67, 8'h6f, 8'h69, 8'h6b, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h77, 8'h79, 8'h7c, 8'h7b, 8'h7d, 8'h7e, 8'h47, 8'h4b, 8'h43, 8'h4e, 8'h45,
        8'h4c, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5b, 8'h5c, 8'h52, 8'h41,
        8'h0a, 8'h6e, 8'h7f, 8'h51, 8'h69, 8'h6b, 8'h71, 8'h6a, 8'h40, 8'h4f, 8'h50, 8'h5a,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h72,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    typedef logic [KEY_SLOTS-1:0][7:0] keys_t;

    typedef struct packed {
        logic [7:0] usage;
        logic       hidq;
        logic [6:0] code;
        logic       cons;
        logic       down;
    } evt_t;

    typedef struct packed {
        logic [7:0] prior_mods;
        keys_t      prior_keys;
        logic [7:0] cur_mods;
        keys_t      cur_keys;
        logic       grabbed;
        logic       rise;
    } ctx_t;

    typedef struct packed {
        logic             running;
        logic             flushing;
        logic [2:0]       phase;
        logic [IDX_W-1:0] idx;
    } seq_t;

endpackage

FILE: src/hkrd_evt.sv
module hkrd_evt (
    input  hkrd_pkg::ctx_t ctx,
    input  hkrd_pkg::seq_t seq,
    output logic           hit,
    output hkrd_pkg::evt_t evt
);

    logic [7:0]          u;
    logic [7:0]          code;
    logic [2:0]          b;
    logic                in_range;
    logic                member;
    logic                rollover;
    logic                cons;
    hkrd_pkg::keys_t     other;

    always_comb
    begin
        b        = seq.idx[2:0];
        u        = (seq.phase == hkrd_pkg::PH_PRS) ? ctx.cur_keys[seq.idx]
                                                   : ctx.prior_keys[seq.idx];
        other    = (seq.phase == hkrd_pkg::PH_PRS) ? ctx.prior_keys : ctx.cur_keys;
        in_range = (u >= hkrd_pkg::MIN_KEY) && (u <= hkrd_pkg::MAX_USAGE);
        code     = hkrd_pkg::LEGACY_ROM[u[6:0]];
        rollover = (ctx.cur_keys[0] == hkrd_pkg::ROLLOVER);
        member   = 1'b0;
        for (int j = 0; j < hkrd_pkg::KEY_SLOTS; j++)
        begin
            if (other[j] == u)
            begin
                member = 1'b1;
            end
        end
        cons = !ctx.grabbed && (code != hkrd_pkg::NO_CODE);

        hit = 1'b0;
        evt = '0;
        unique case (seq.phase)
            hkrd_pkg::PH_GMOD:
            begin
                hit       = ctx.rise && ctx.prior_mods[b];
                evt.usage = {hkrd_pkg::MOD_BASE, b};
                evt.hidq  = 1'b0;
                evt.code  = hkrd_pkg::MOD_ROM[b];
                evt.cons  = 1'b1;
                evt.down  = 1'b0;
            end
            hkrd_pkg::PH_GKEY:
            begin
                hit       = ctx.rise && in_range && (code != hkrd_pkg::NO_CODE);
                evt.usage = u;
                evt.hidq  = 1'b0;
                evt.code  = code[6:0];
                evt.cons  = 1'b1;
                evt.down  = 1'b0;
            end
            hkrd_pkg::PH_MOD:
            begin
                hit       = !rollover && (ctx.cur_mods[b] != ctx.prior_mods[b]);
                evt.usage = {hkrd_pkg::MOD_BASE, b};
                evt.hidq  = 1'b1;
                evt.code  = ctx.grabbed ? 7'd0 : hkrd_pkg::MOD_ROM[b];
                evt.cons  = !ctx.grabbed;
                evt.down  = ctx.cur_mods[b];
            end
            hkrd_pkg::PH_REL, hkrd_pkg::PH_PRS:
            begin
                hit       = !rollover && in_range && !member;
                evt.usage = u;
                evt.hidq  = 1'b1;
                evt.code  = cons ? code[6:0] : 7'd0;
                evt.cons  = cons;
                evt.down  = (seq.phase == hkrd_pkg::PH_PRS);
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/hkrd_seq.sv
module hkrd_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           adv,
    input  logic           flush_go,
    output hkrd_pkg::seq_t seq
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [2:0]                 phase_reg, phase_next;
    logic [hkrd_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [hkrd_pkg::IDX_W-1:0] last_idx;

    always_comb
    begin
        last_idx = ((phase_reg == hkrd_pkg::PH_GMOD) || (phase_reg == hkrd_pkg::PH_MOD))
                   ? hkrd_pkg::MOD_LAST : hkrd_pkg::KEY_LAST;
        state_next = state_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    phase_next = hkrd_pkg::PH_GMOD;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (idx_reg == last_idx)
                    begin
                        idx_next = '0;
                        if (phase_reg == hkrd_pkg::PH_PRS)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (flush_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= hkrd_pkg::PH_GMOD;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    assign seq.running  = (state_reg == ST_RUN);
    assign seq.flushing = (state_reg == ST_FLUSH);
    assign seq.phase    = phase_reg;
    assign seq.idx      = idx_reg;

endmodule

FILE: src/hid_keyboard_report_differ.sv
// Boot keyboard report differ. Each accepted report is compared with the one
// kept from before and turned into a run of key events on the output channel;
// the final event of a report carries last_event, and a report that changes
// nothing gives no event. One shared event unit checks one candidate per cycle
// unless a found event waits for room at the output (8 grab modifier releases,
// 6 grab key releases, 8 modifier changes, 6 key releases, 6 key presses), and
// a flush step then marks the last event. in_ready stays low until the flush is
// done, so a new report is taken only once the last one is through. The newest
// event is held back one step so it can be marked last; output stalls stretch
// the walk.
module hid_keyboard_report_differ (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] modifier_bits,
    input  logic [7:0] key_slot_0,
    input  logic [7:0] key_slot_1,
    input  logic [7:0] key_slot_2,
    input  logic [7:0] key_slot_3,
    input  logic [7:0] key_slot_4,
    input  logic [7:0] key_slot_5,
    input  logic       console_grabbed,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] hid_usage,
    output logic       to_hid_queue,
    output logic [6:0] legacy_code,
    output logic       to_console,
    output logic       key_down,
    output logic       last_event
);

    hkrd_pkg::seq_t  seq;
    hkrd_pkg::ctx_t  ctx;
    hkrd_pkg::evt_t  evt;
    logic            hit;

    logic [7:0]      prior_mods_reg;
    hkrd_pkg::keys_t prior_keys_reg;
    logic [7:0]      cur_mods_reg;
    hkrd_pkg::keys_t cur_keys_reg;
    logic            grab_reg;
    logic            rise_reg;

    hkrd_pkg::evt_t  hold_reg;
    logic            hold_valid_reg, hold_valid_next;
    hkrd_pkg::evt_t  out_reg;
    logic            out_last_reg;
    logic            out_valid_reg, out_valid_next;

    logic            accept;
    logic            out_free;
    logic            adv;
    logic            flush_go;
    logic            take;
    logic            push;
    logic            finish;

    assign in_ready = !seq.running && !seq.flushing;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign ctx.prior_mods = prior_mods_reg;
    assign ctx.prior_keys = prior_keys_reg;
    assign ctx.cur_mods   = cur_mods_reg;
    assign ctx.cur_keys   = cur_keys_reg;
    assign ctx.grabbed    = grab_reg;
    assign ctx.rise       = rise_reg;

    hkrd_evt u_evt (
        .ctx (ctx),
        .seq (seq),
        .hit (hit),
        .evt (evt)
    );

    // A found event moves the held one to the output, so it must have room.
    assign adv      = !hit || !hold_valid_reg || out_free;
    assign take     = seq.running && hit && adv;
    assign push     = take && hold_valid_reg;
    assign flush_go = !hold_valid_reg || out_free;
    assign finish   = seq.flushing && flush_go;

    hkrd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .adv      (adv),
        .flush_go (flush_go),
        .seq      (seq)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (finish)
        begin
            hold_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (push || (finish && hold_valid_reg))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_mods_reg <= '0;
            prior_keys_reg <= '0;
            grab_reg       <= 1'b0;
            rise_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (accept)
            begin
                grab_reg <= console_grabbed;
                rise_reg <= console_grabbed && !grab_reg;
            end
            if (finish)
            begin
                prior_mods_reg <= cur_mods_reg;
                prior_keys_reg <= cur_keys_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_mods_reg    <= modifier_bits;
            cur_keys_reg[0] <= key_slot_0;
            cur_keys_reg[1] <= key_slot_1;
            cur_keys_reg[2] <= key_slot_2;
            cur_keys_reg[3] <= key_slot_3;
            cur_keys_reg[4] <= key_slot_4;
            cur_keys_reg[5] <= key_slot_5;
        end
        if (take)
        begin
            hold_reg <= evt;
        end
        if (push)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b0;
        end
        else if (finish && hold_valid_reg)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hid_usage    = out_reg.usage;
    assign to_hid_queue = out_reg.hidq;
    assign legacy_code  = out_reg.code;
    assign to_console   = out_reg.cons;
    assign key_down     = out_reg.down;
    assign last_event   = out_last_reg;

endmodule
